>>> hdl/crc16_checked_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Frame receiver assertion macros
// Concurrent assertion shorthands with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CRC16_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/crc16_cfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Item types, status codes and frame constants shared by the receiver files.
// ----------------------------------------------------------------------------
package crc16_cfr_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 255;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  TERMINATOR      = 8'hFF;
    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd5;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_VALID    = 3'd1,
        ST_CRC_BAD  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_TIMEOUT  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timeout;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        t_status    status;
        logic [7:0] frame_size;
        logic [7:0] action_code;
    } t_out_item;

    // Flow control between the result buffer and the input stage.
    typedef struct packed {
        logic wr;
        logic space;
    } t_buf_ctrl;

endpackage

>>> hdl/crc16_cfr_ifs.sv
// ----------------------------------------------------------------------------
// Frame receiver channels
// Valid/ready channels for received bytes and for per-byte results.
// ----------------------------------------------------------------------------
interface crc16_cfr_in_if import crc16_cfr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface crc16_cfr_out_if import crc16_cfr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/crc16_cfr_crc_fold.sv
// ----------------------------------------------------------------------------
// CRC-16 byte fold
// Folds one byte into a reflected CRC-16 (polynomial 0xA001), eight bit steps.
// ----------------------------------------------------------------------------
module crc16_cfr_crc_fold import crc16_cfr_pkg::*; (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v;
        v = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

>>> hdl/crc16_cfr_frame.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Holds the per-frame state, classifies each item and updates on each step.
// ----------------------------------------------------------------------------
module crc16_cfr_frame import crc16_cfr_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam logic [7:0] MAX_BYTES = 8'(MAX_FRAME_BYTES);

    logic [7:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_decl_len,   n_decl_len;
    logic [15:0] r_crc,        n_crc;
    logic [7:0]  r_older,      n_older;
    logic [7:0]  r_newer,      n_newer;
    logic [7:0]  r_action,     n_action;

    logic [15:0] w_crc_fold;
    logic [7:0]  w_count;
    logic [7:0]  w_decl;
    logic [7:0]  w_act;
    logic        w_close;
    logic        w_over;

    crc16_cfr_crc_fold u_fold (
        .i_crc  (r_crc),
        .i_byte (r_older),
        .o_crc  (w_crc_fold)
    );

    always_comb begin
        w_count = r_byte_count + 8'd1;
        w_decl  = (r_byte_count == 8'd0) ? i_item.rx_byte : r_decl_len;
        w_act   = (r_byte_count == 8'd1) ? i_item.rx_byte : r_action;
        w_close = (i_item.rx_byte == TERMINATOR) && (w_count >= w_decl);
        w_over  = (w_count >= MAX_BYTES);

        o_result.data_byte   = i_item.rx_byte;
        o_result.byte_index  = r_byte_count;
        o_result.frame_end   = 1'b0;
        o_result.status      = ST_PROGRESS;
        o_result.frame_size  = 8'd0;
        o_result.action_code = w_act;

        // hold by default
        n_byte_count = r_byte_count;
        n_decl_len   = r_decl_len;
        n_crc        = r_crc;
        n_older      = r_older;
        n_newer      = r_newer;
        n_action     = r_action;

        if (i_item.timeout) begin
            o_result.data_byte   = 8'd0;
            o_result.frame_end   = 1'b1;
            o_result.status      = ST_TIMEOUT;
            o_result.action_code = r_action;
        end else if (w_close) begin
            o_result.frame_end  = 1'b1;
            o_result.frame_size = w_count;
            if (w_count < MIN_FRAME_BYTES) begin
                o_result.status = ST_SHORT;
            end else if ({r_older, r_newer} == r_crc) begin
                o_result.status = ST_VALID;
            end else begin
                o_result.status = ST_CRC_BAD;
            end
        end else if (w_over) begin
            o_result.frame_end  = 1'b1;
            o_result.frame_size = w_count;
            o_result.status     = ST_OVERFLOW;
        end else begin
            // advance: fold the byte leaving the two-byte delay
            if (r_byte_count >= 8'd2) begin
                n_crc = w_crc_fold;
            end
            n_older      = r_newer;
            n_newer      = i_item.rx_byte;
            n_byte_count = w_count;
            n_decl_len   = w_decl;
            n_action     = w_act;
        end

        if (o_result.frame_end) begin
            // drop the frame state
            n_byte_count = 8'd0;
            n_decl_len   = 8'd0;
            n_crc        = CRC_INIT;
            n_older      = 8'd0;
            n_newer      = 8'd0;
            n_action     = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 8'd0;
            r_decl_len   <= 8'd0;
            r_crc        <= CRC_INIT;
            r_older      <= 8'd0;
            r_newer      <= 8'd0;
            r_action     <= 8'd0;
        end else if (i_step) begin
            r_byte_count <= n_byte_count;
            r_decl_len   <= n_decl_len;
            r_crc        <= n_crc;
            r_older      <= n_older;
            r_newer      <= n_newer;
            r_action     <= n_action;
        end
    end

endmodule

>>> hdl/crc16_cfr_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result queue; lets the input side run while a result waits.
// ----------------------------------------------------------------------------
module crc16_cfr_out_buf import crc16_cfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_out_item i_item,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = i_wr  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_wr} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hdl/crc16_checked_frame_receiver.sv
// A byte is held in the input register; its result is written to the result buffer and offered from it.
// Throughput: one item per cycle while the buffer has space; the CRC fold is one combinational byte step.
// Input stalls only when the two-entry result buffer is full and the input register holds.
// Reset: synchronous, active low; empties both stages and returns the CRC to 0xFFFF.
// ----------------------------------------------------------------------------
// CRC-16 checked frame receiver
// Delimits length-prefixed frames (length, action, payload, CRC hi/lo, 0xFF),
// checks the Modbus CRC-16 and emits one result item per received item.
// ----------------------------------------------------------------------------
`include "crc16_checked_frame_receiver_assert.svh"

module crc16_checked_frame_receiver import crc16_cfr_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    crc16_cfr_in_if.sink           i_in,
    crc16_cfr_out_if.source        o_out
);

    // Input register: one item waiting to be classified.
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_item;

    t_buf_ctrl w_buf;
    t_out_item w_res;
    logic      w_accept;
    logic      w_buf_space;

    // Step the frame tracker when the buffer can take its result.
    assign w_buf.space = w_buf_space;
    assign w_buf.wr    = r_in_valid && w_buf.space;

    // Take a new item when the input register is empty or drains this cycle.
    assign i_in.ready = !r_in_valid || w_buf.wr;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_buf.wr) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload holds without reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in.payload;
        end
    end

    crc16_cfr_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_buf.wr),
        .i_item   (r_in_item),
        .o_result (w_res)
    );

    crc16_cfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_buf.wr),
        .i_item  (w_res),
        .o_space (w_buf_space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.payload)
    );

    // A byte that does not end a frame reports progress and no length.
    `CFR_ASSERT_IMPL(a_progress_no_len, i_clk, i_rst_n, w_buf.wr && !w_res.frame_end, w_res.status == ST_PROGRESS && w_res.frame_size == 8'd0, "progress item with status or length")
    // A frame closed by its terminator or by overflow counts its closing byte.
    `CFR_ASSERT_IMPL(a_len_matches_idx, i_clk, i_rst_n, w_buf.wr && w_res.frame_end && !r_in_item.timeout, w_res.frame_size == w_res.byte_index + 8'd1, "frame length differs from byte index")
    // An accepted item lands in the input register.
    `CFR_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, w_accept, r_in_valid, "accepted item not held")

endmodule

>>> sim/crc16_checked_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Sends byte and timeout items through the input channel and checks every
// result against a cycle-free model of the framing, CRC and status rules.
// A directed prologue covers the corner cases, then random well-formed and
// broken frames follow. Both channels idle at random, and the result side
// holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module crc16_checked_frame_receiver_tb;
    import crc16_cfr_pkg::*;

    localparam int unsigned ITEM_TARGET   = 1950;
    localparam int unsigned IDLE_LIMIT    = 1000;  // cycles with no handshake on either side
    localparam int unsigned HOLD_OFF_LEN  = 150;
    localparam int unsigned HOLD_OFF_AT   = 300;
    localparam int unsigned DRAIN_CYCLES  = 8;     // results pass the input register and the result buffer
    localparam int unsigned PRINT_CAP     = 40;
    localparam int          SIDE_SEND     = 0;
    localparam int          SIDE_RECV     = 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crc16_cfr_in_if  in_ch ();
    crc16_cfr_out_if out_ch ();

    crc16_checked_frame_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Stimulus and expectation stores.
    t_in_item    rx_items_pending[$];
    t_out_item   rx_results_due[$];
    logic [7:0]  frame_bytes[$];

    // Model state of the frame being received.
    logic [7:0]  frm_count    = '0;
    logic [7:0]  frm_declared = '0;
    logic [15:0] frm_crc      = CRC_INIT;
    logic [7:0]  crc_hold_older = '0;
    logic [7:0]  crc_hold_newer = '0;
    logic [7:0]  frm_action   = '0;

    // Handshake pacing.
    int unsigned send_gap  = 0;
    int unsigned recv_wait = 0;
    bit          calm_mode[2] = '{1'b0, 1'b0};
    bit          hold_off;

    int unsigned items_in    = 0;
    int unsigned results_out = 0;
    int unsigned mismatches  = 0;
    t_out_item   result_got;
    t_out_item   result_want;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the receiver
    // ------------------------------------------------------------------------

    // Fold one byte into a Modbus CRC, LSB first.
    function automatic logic [15:0] crc16_fold_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        frm_count      = '0;
        frm_declared   = '0;
        frm_crc        = CRC_INIT;
        crc_hold_older = '0;
        crc_hold_newer = '0;
        frm_action     = '0;
    endfunction

    // Work out the result of one accepted item and advance the frame state.
    function automatic t_out_item predict_rx_result(t_in_item it);
        t_out_item   r;
        logic [7:0]  idx;
        int unsigned cnt;
        r = '0;
        // A timeout drops whatever partial frame is held, even an empty one.
        if (it.timeout) begin
            r.byte_index  = frm_count;
            r.frame_end   = 1'b1;
            r.status      = ST_TIMEOUT;
            r.action_code = frm_action;
            clear_frame_state();
            return r;
        end
        idx = frm_count;
        cnt = frm_count + 32'd1;
        if (idx == 8'd0) begin
            frm_declared = it.rx_byte;
        end
        if (idx == 8'd1) begin
            frm_action = it.rx_byte;
        end
        r.data_byte   = it.rx_byte;
        r.byte_index  = idx;
        r.action_code = frm_action;
        r.status      = ST_PROGRESS;
        if (it.rx_byte == TERMINATOR && cnt >= frm_declared) begin
            // The two held bytes are the CRC, high byte first.
            r.frame_end  = 1'b1;
            r.frame_size = cnt[7:0];
            if (cnt < MIN_FRAME_BYTES) begin
                r.status = ST_SHORT;
            end else if ({crc_hold_older, crc_hold_newer} == frm_crc) begin
                r.status = ST_VALID;
            end else begin
                r.status = ST_CRC_BAD;
            end
        end else if (cnt >= MAX_FRAME_BYTES_DEF) begin
            r.frame_end  = 1'b1;
            r.frame_size = cnt[7:0];
            r.status     = ST_OVERFLOW;
        end else begin
            // The CRC trails the input by two bytes.
            if (idx >= 8'd2) begin
                frm_crc = crc16_fold_byte(frm_crc, crc_hold_older);
            end
            crc_hold_older = crc_hold_newer;
            crc_hold_newer = it.rx_byte;
            frm_count      = cnt[7:0];
        end
        if (r.frame_end) begin
            clear_frame_state();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        t_in_item it;
        it.rx_byte = b;
        it.timeout = 1'b0;
        rx_items_pending.push_back(it);
    endtask

    // The byte lane carries junk on a timeout; the block must ignore it.
    task automatic queue_timeout();
        t_in_item it;
        it.rx_byte = 8'($urandom_range(0, 255));
        it.timeout = 1'b1;
        rx_items_pending.push_back(it);
    endtask

    task automatic queue_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            queue_byte(frame_bytes[i]);
        end
    endtask

    // Build a frame of len bytes with a correct CRC; the length byte may lie.
    task automatic build_frame(input int unsigned len, input logic [7:0] declared,
                               input logic [7:0] action);
        logic [15:0] c;
        frame_bytes.delete();
        frame_bytes.push_back(declared);
        frame_bytes.push_back(action);
        for (int unsigned i = 5; i < len; i++) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        c = CRC_INIT;
        foreach (frame_bytes[i]) begin
            c = crc16_fold_byte(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(TERMINATOR);
    endtask

    // No terminator anywhere: the count runs into the frame limit.
    task automatic queue_overflow_frame();
        for (int unsigned i = 0; i < MAX_FRAME_BYTES_DEF; i++) begin
            queue_byte(8'($urandom_range(0, 254)));
        end
    endtask

    // Mostly short frames, now and then a long one up to the limit.
    function automatic int unsigned pick_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(25, 255) : $urandom_range(5, 24);
    endfunction

    function automatic int unsigned draw_wait(int side);
        if ($urandom_range(0, 49) == 0) begin
            calm_mode[side] = !calm_mode[side];
        end
        return calm_mode[side] ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned res_no,
                                   input logic [7:0] got, input logic [7:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] result %0d %s: got %0h, expected %0h", $realtime, res_no, what,
                     got, want);
        end
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Reset and known start values
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        hold_off      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: present pending items, predict each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                rx_results_due.push_back(predict_rx_result(in_ch.payload));
                items_in++;
            end
            // Change the offer only when it was taken or nothing is offered.
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (rx_items_pending.size() > 0) begin
                    in_ch.payload <= rx_items_pending.pop_front();
                    in_ch.valid   <= 1'b1;
                    send_gap = draw_wait(SIDE_SEND);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take results, check them field by field against the model
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                result_got = out_ch.payload;
                if (rx_results_due.size() == 0) begin
                    report_mismatch("arrived with nothing due", results_out,
                                    result_got.data_byte, 8'h00);
                end else begin
                    result_want = rx_results_due.pop_front();
                    if (result_got.data_byte !== result_want.data_byte)
                        report_mismatch("data_byte", results_out,
                                        result_got.data_byte, result_want.data_byte);
                    if (result_got.byte_index !== result_want.byte_index)
                        report_mismatch("byte_index", results_out,
                                        result_got.byte_index, result_want.byte_index);
                    if (result_got.frame_end !== result_want.frame_end)
                        report_mismatch("frame_end", results_out,
                                        8'(result_got.frame_end), 8'(result_want.frame_end));
                    if (result_got.status !== result_want.status)
                        report_mismatch("status", results_out,
                                        8'(result_got.status), 8'(result_want.status));
                    if (result_got.frame_size !== result_want.frame_size)
                        report_mismatch("frame_size", results_out,
                                        result_got.frame_size, result_want.frame_size);
                    if (result_got.action_code !== result_want.action_code)
                        report_mismatch("action_code", results_out,
                                        result_got.action_code, result_want.action_code);
                end
                results_out++;
                recv_wait = draw_wait(SIDE_RECV);
            end
            // Hold ready low through the drawn wait and the long hold-off.
            if (hold_off || recv_wait > 0) begin
                out_ch.ready <= 1'b0;
                if (recv_wait > 0) begin
                    recv_wait--;
                end
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Hold the result side off once, long enough to fill the block and stall
    // its input while the driver keeps offering items.
    initial begin
        wait (items_in >= HOLD_OFF_AT);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned n;
        logic [7:0]  declared;

        // Directed corner cases.
        queue_timeout();                        // timeout with no partial frame
        queue_byte(8'd3);                       // too short, closes on its terminator
        queue_byte(8'h00);
        queue_byte(TERMINATOR);
        build_frame(5, 8'd5, 8'hFF);            // shortest valid frame, action all ones
        queue_bytes(5);
        build_frame(6, 8'd6, 8'h00);            // one payload bit flipped: CRC mismatch
        frame_bytes[2] ^= 8'h01;
        queue_bytes(6);
        build_frame(8, 8'd8, 8'($urandom_range(0, 255)));
        queue_bytes(3);                         // partial frame dropped by a timeout
        queue_timeout();
        build_frame(5, 8'd0, 8'($urandom_range(0, 255)));
        queue_bytes(5);                         // declared length zero
        queue_overflow_frame();                 // runs into the frame limit
        build_frame(MAX_FRAME_BYTES_DEF, 8'(MAX_FRAME_BYTES_DEF),
                    8'($urandom_range(0, 255)));
        queue_bytes(MAX_FRAME_BYTES_DEF);       // longest valid frame

        // Random part: mostly well-formed frames, mixed with broken ones and noise.
        while (rx_items_pending.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            len  = pick_len();
            if (pick < 45) begin
                build_frame(len, 8'(len), 8'($urandom_range(0, 255)));
                queue_bytes(len);
            end else if (pick < 60) begin
                // Corrupt one byte between the length byte and the terminator.
                build_frame(len, 8'(len), 8'($urandom_range(0, 255)));
                frame_bytes[$urandom_range(1, len - 2)] ^= 8'($urandom_range(1, 255));
                queue_bytes(len);
            end else if (pick < 70) begin
                declared = 8'($urandom_range(0, 4));
                n = (declared > 8'd2) ? $urandom_range(declared - 2, 2) : $urandom_range(0, 2);
                queue_byte(declared);
                repeat (n) queue_byte(8'($urandom_range(0, 254)));
                queue_byte(TERMINATOR);
            end else if (pick < 80) begin
                build_frame(len, 8'(len), 8'($urandom_range(0, 255)));
                queue_bytes($urandom_range(1, len - 1));
                queue_timeout();
            end else if (pick < 85) begin
                // Declared length below the real one: any early terminator closes it.
                build_frame(len, 8'($urandom_range(0, len - 1)), 8'($urandom_range(0, 255)));
                queue_bytes(len);
                queue_timeout();
            end else if (pick < 95) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) queue_timeout();
                    else queue_byte(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 3) != 0) queue_timeout();
            end else if (pick < 99) begin
                queue_timeout();
            end else if ($urandom_range(0, 1) == 0) begin
                queue_overflow_frame();
            end else begin
                build_frame(MAX_FRAME_BYTES_DEF, 8'(MAX_FRAME_BYTES_DEF),
                            8'($urandom_range(0, 255)));
                queue_bytes(MAX_FRAME_BYTES_DEF);
            end
        end

        // Wait until every item is taken and every result has come back.
        do begin
            @(negedge i_clk);
        end while (rx_items_pending.size() != 0 || in_ch.valid || rx_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
